>>> hw/rtl/etns_pkg.sv
// ----------------------------------------------------------------------------
// etns_pkg
// Shared constants, codes and types of the entity table nearest search block.
// ----------------------------------------------------------------------------
package etns_pkg;

   // Table geometry.
   localparam int MAX_ENTITIES = 16;
   localparam int MAX_RESULTS  = 16;
   localparam int SLOT_W       = $clog2(MAX_ENTITIES);
   localparam int CNT_W        = $clog2(MAX_ENTITIES + 1);
   localparam int HITS_W       = $clog2(MAX_RESULTS + 1);

   // Field widths.
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 3;
   localparam int KEY_W        = 32;
   localparam int BYTE_W       = 8;
   localparam int REACH_W      = 9;
   localparam int DIST_W       = 17;
   localparam int LIMIT_W      = 18;
   localparam int SLOT_FIELD_W = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_UPDATE  = 2'd0,
      CMD_NEAREST = 2'd1,
      CMD_RANGE   = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_MATCH    = 3'd3,
      ST_NO_MATCH = 3'd4,
      ST_UNKNOWN  = 3'd5
   } status_type;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [BYTE_W-1:0] kind;
      logic [BYTE_W-1:0] x;
      logic [BYTE_W-1:0] y;
      logic              alive;
   } entry_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [KEY_W-1:0]   key;
      logic [BYTE_W-1:0]  kind;
      logic [BYTE_W-1:0]  pos_x;
      logic [BYTE_W-1:0]  pos_y;
      logic               alive;
      logic [REACH_W-1:0] reach;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [KEY_W-1:0]        hit_key;
      logic [BYTE_W-1:0]       hit_kind;
      logic [BYTE_W-1:0]       hit_x;
      logic [BYTE_W-1:0]       hit_y;
      logic [DIST_W-1:0]       dist_sq;
      logic                    last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     flush;    // new beat accepted: latch it and clear search state
      logic     rd_en;    // read the table at rd_addr
      slot_type rd_addr;
      logic     consume;  // evaluate the entry in the read register
      logic     scan;     // 0 during key lookup, 1 during distance scan
      logic     finish;   // issue the closing result
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    q_vld;
      logic    q_last;
      logic    stall;
      logic    hits_full;
      logic    found;
      logic    out_free;
   } dp_stat_type;

   // Low bits of a slot number as carried in the result's slot field.
   function automatic logic [SLOT_FIELD_W-1:0] slot_field(input slot_type idx);
      logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
      ext = {{SLOT_FIELD_W{1'b0}}, idx};
      return ext[SLOT_FIELD_W-1:0];
   endfunction

endpackage

>>> hw/rtl/etns_req_if.sv
// ----------------------------------------------------------------------------
// etns_req_if
// Request channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface etns_req_if;
   import etns_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [KEY_W-1:0]   key;
   logic [BYTE_W-1:0]  kind;
   logic [BYTE_W-1:0]  pos_x;
   logic [BYTE_W-1:0]  pos_y;
   logic               alive;
   logic [REACH_W-1:0] reach;

   modport source (output valid, cmd, key, kind, pos_x, pos_y, alive, reach,
                   input ready);
   modport sink (input valid, cmd, key, kind, pos_x, pos_y, alive, reach,
                 output ready);
endinterface

>>> hw/rtl/etns_rsp_if.sv
// ----------------------------------------------------------------------------
// etns_rsp_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface etns_rsp_if;
   import etns_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [SLOT_FIELD_W-1:0] slot;
   logic [KEY_W-1:0]        hit_key;
   logic [BYTE_W-1:0]       hit_kind;
   logic [BYTE_W-1:0]       hit_x;
   logic [BYTE_W-1:0]       hit_y;
   logic [DIST_W-1:0]       dist_sq;
   logic                    last;

   modport source (output valid, status, slot, hit_key, hit_kind, hit_x, hit_y,
                   dist_sq, last, input ready);
   modport sink (input valid, status, slot, hit_key, hit_kind, hit_x, hit_y,
                 dist_sq, last, output ready);
endinterface

>>> hw/rtl/entity_table_nearest_search_top.sv
// Each request runs to its closing result before the next request is accepted;
// range hits leave during the scan, which stalls while a range result waits on the
// response side. The table memory has one read port, scanned once for the key and
// once more for distances.
// Reset: slot valid bits clear at once; table contents stay undefined, no clear pass.
// ----------------------------------------------------------------------------
// entity_table_nearest_search_top
// Entity table with update/insert, nearest query and range query.
// ----------------------------------------------------------------------------
module entity_table_nearest_search_top (
   input  logic   clock,
   input  logic   reset,
   etns_req_if.sink   req_bus,
   etns_rsp_if.source rsp_bus
);
   import etns_pkg::*;

   // The request beat is unpacked into one struct for the datapath, which
   // latches it on the accepting edge. Only the command code goes to the
   // controller so that it can drop the unused command without a pass.
   req_type     req_data;
   rsp_type     rsp_data;
   ctl_cmd_type ctl;
   dp_stat_type stat;
   logic        req_ready;
   logic        rsp_valid;

   always_comb begin
      req_data.cmd   = cmd_type'(req_bus.cmd);
      req_data.key   = req_bus.key;
      req_data.kind  = req_bus.kind;
      req_data.pos_x = req_bus.pos_x;
      req_data.pos_y = req_bus.pos_y;
      req_data.alive = req_bus.alive;
      req_data.reach = req_bus.reach;
   end

   // The controller walks the table: a key lookup pass, then for queries a
   // distance scan pass, then one closing result. It only sequences; every
   // value lives in the datapath.
   etns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // The datapath holds the entity memory, the valid bits, the distance unit
   // and the response output register, which lets a result beat wait for the
   // sink while a range scan goes on to the next hit.
   etns_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign req_bus.ready    = req_ready;
   assign rsp_bus.valid    = rsp_valid;
   assign rsp_bus.status   = rsp_data.status;
   assign rsp_bus.slot     = rsp_data.slot;
   assign rsp_bus.hit_key  = rsp_data.hit_key;
   assign rsp_bus.hit_kind = rsp_data.hit_kind;
   assign rsp_bus.hit_x    = rsp_data.hit_x;
   assign rsp_bus.hit_y    = rsp_data.hit_y;
   assign rsp_bus.dist_sq  = rsp_data.dist_sq;
   assign rsp_bus.last     = rsp_data.last;

endmodule

>>> hw/rtl/etns_ctrl.sv
// ----------------------------------------------------------------------------
// etns_ctrl
// Sequencer: key lookup pass, distance scan pass and closing result.
// ----------------------------------------------------------------------------
module etns_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  etns_pkg::cmd_type      req_cmd,
   output logic                   req_ready,
   input  etns_pkg::dp_stat_type  stat,
   output etns_pkg::ctl_cmd_type  ctl
);
   import etns_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN, S_FINISH} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               scanning;
   logic               halt;
   logic               accept;

   always_comb begin
      scanning  = (state_ff == S_LOOK) || (state_ff == S_SCAN);
      // A range scan that has collected its full quota of hits stops at once.
      halt      = stat.stall || ((state_ff == S_SCAN) && stat.hits_full);
      accept    = (state_ff == S_IDLE) && req_valid;
      req_ready = (state_ff == S_IDLE);

      ctl.flush   = accept;
      ctl.rd_en   = scanning && (iss_ff < CNT_W'(MAX_ENTITIES)) && !halt;
      ctl.rd_addr = iss_ff[SLOT_W-1:0];
      ctl.consume = scanning && stat.q_vld && !halt;
      ctl.scan    = (state_ff == S_SCAN);
      ctl.finish  = (state_ff == S_FINISH) && stat.out_free;

      state_in = state_ff;
      iss_in   = ctl.rd_en ? iss_ff + CNT_W'(1) : iss_ff;

      case (state_ff)
         S_IDLE: begin
            iss_in = '0;
            if (accept && (req_cmd != CMD_NONE)) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (ctl.consume && stat.q_last) begin
               iss_in = '0;
               if ((stat.cmd == CMD_UPDATE) || !stat.found) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (stat.hits_full || (ctl.consume && stat.q_last)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iss_ff   <= '0;
      end else begin
         state_ff <= state_in;
         iss_ff   <= iss_in;
      end
   end

endmodule

>>> hw/rtl/etns_dp.sv
// ----------------------------------------------------------------------------
// etns_dp
// Datapath: entity memory, slot valid bits, distance unit, best/pending hit
// register and the response output register.
// ----------------------------------------------------------------------------
module etns_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  etns_pkg::req_type      req_data,
   input  etns_pkg::ctl_cmd_type  ctl,
   output etns_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output etns_pkg::rsp_type      rsp_data
);
   import etns_pkg::*;

   // Entity memory and its registered read port.
   entry_type               mem_ff [MAX_ENTITIES];
   entry_type               q_ff;
   slot_type                q_idx_ff;
   logic                    q_vld_ff, q_vld_in;
   logic [MAX_ENTITIES-1:0] valid_ff, valid_in;

   // Latched request.
   req_type                 cur_ff;
   logic [LIMIT_W-1:0]      limit_ff;

   // Lookup results.
   logic                    found_ff, found_in;
   slot_type                found_idx_ff, found_idx_in;
   logic [BYTE_W-1:0]       seek_x_ff, seek_x_in;
   logic [BYTE_W-1:0]       seek_y_ff, seek_y_in;
   logic                    free_ff, free_in;
   slot_type                free_idx_ff, free_idx_in;

   // Best hit for a nearest query, pending hit for a range query.
   logic                    have_ff, have_in;
   slot_type                hold_idx_ff, hold_idx_in;
   entry_type               hold_ent_ff, hold_ent_in;
   logic [DIST_W-1:0]       hold_d2_ff, hold_d2_in;
   logic [HITS_W-1:0]       hits_ff, hits_in;

   // Output register.
   logic                    rsp_vld_ff, rsp_vld_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    slot_ok;
   logic                    look_hit;
   logic                    cand;
   logic [BYTE_W-1:0]       adx, ady;
   logic [DIST_W-1:0]       d2;
   logic                    range_hit;
   logic                    better;
   logic                    out_free;
   logic                    stall;
   logic                    look_step;
   logic                    scan_step;
   logic                    push_mid;
   logic                    push;
   logic                    wr_en;
   slot_type                wr_idx;

   always_comb begin
      slot_ok  = valid_ff[q_idx_ff];
      look_hit = q_vld_ff && slot_ok && (q_ff.key == cur_ff.key);
      cand     = q_vld_ff && slot_ok && q_ff.alive && (q_idx_ff != found_idx_ff);

      adx = (q_ff.x >= seek_x_ff) ? q_ff.x - seek_x_ff : seek_x_ff - q_ff.x;
      ady = (q_ff.y >= seek_y_ff) ? q_ff.y - seek_y_ff : seek_y_ff - q_ff.y;
      d2  = DIST_W'(adx) * DIST_W'(adx) + DIST_W'(ady) * DIST_W'(ady);

      range_hit = cand && (cur_ff.cmd == CMD_RANGE) && ({1'b0, d2} <= limit_ff);
      better    = cand && (cur_ff.cmd == CMD_NEAREST) && (!have_ff || (d2 < hold_d2_ff));
      out_free  = !rsp_vld_ff || rsp_ready;
      // A new range hit can only displace the pending one into a free output.
      stall     = ctl.scan && range_hit && have_ff && !out_free;

      look_step = ctl.consume && !ctl.scan;
      scan_step = ctl.consume && ctl.scan;
      push_mid  = scan_step && range_hit && have_ff;
      push      = push_mid || ctl.finish;

      wr_en  = ctl.finish && (cur_ff.cmd == CMD_UPDATE) && (found_ff || free_ff);
      wr_idx = found_ff ? found_idx_ff : free_idx_ff;

      stat.cmd       = cur_ff.cmd;
      stat.q_vld     = q_vld_ff;
      stat.q_last    = (q_idx_ff == SLOT_W'(MAX_ENTITIES - 1));
      stat.stall     = stall;
      stat.hits_full = (hits_ff == HITS_W'(MAX_RESULTS));
      stat.found     = found_ff || (look_step && look_hit);
      stat.out_free  = out_free;
   end

   // Search state next values.
   always_comb begin
      q_vld_in     = ctl.rd_en || (q_vld_ff && !ctl.consume && !ctl.flush);
      valid_in     = valid_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      seek_x_in    = seek_x_ff;
      seek_y_in    = seek_y_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      have_in      = have_ff;
      hold_idx_in  = hold_idx_ff;
      hold_ent_in  = hold_ent_ff;
      hold_d2_in   = hold_d2_ff;
      hits_in      = hits_ff;

      if (ctl.flush) begin
         found_in = 1'b0;
         free_in  = 1'b0;
         have_in  = 1'b0;
         hits_in  = '0;
      end
      if (look_step) begin
         if (look_hit && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = q_idx_ff;
            seek_x_in    = q_ff.x;
            seek_y_in    = q_ff.y;
         end
         if (!slot_ok && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = q_idx_ff;
         end
      end
      if (scan_step && (better || range_hit)) begin
         have_in     = 1'b1;
         hold_idx_in = q_idx_ff;
         hold_ent_in = q_ff;
         hold_d2_in  = d2;
      end
      if (scan_step && range_hit) begin
         hits_in = hits_ff + HITS_W'(1);
      end
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   // Result selection.
   always_comb begin
      rsp_vld_in = push || (rsp_vld_ff && !rsp_ready);
      rsp_in     = rsp_ff;
      if (push) begin
         rsp_in = '{status: ST_NO_MATCH, slot: '0, hit_key: '0, hit_kind: '0,
                    hit_x: '0, hit_y: '0, dist_sq: '0, last: 1'b1};
         if (push_mid) begin
            rsp_in.status   = ST_MATCH;
            rsp_in.slot     = slot_field(hold_idx_ff);
            rsp_in.hit_key  = hold_ent_ff.key;
            rsp_in.hit_kind = hold_ent_ff.kind;
            rsp_in.hit_x    = hold_ent_ff.x;
            rsp_in.hit_y    = hold_ent_ff.y;
            rsp_in.dist_sq  = hold_d2_ff;
            rsp_in.last     = 1'b0;
         end else begin
            case (cur_ff.cmd)
               CMD_UPDATE: begin
                  if (found_ff) begin
                     rsp_in.status = ST_UPDATED;
                     rsp_in.slot   = slot_field(found_idx_ff);
                  end else if (free_ff) begin
                     rsp_in.status = ST_INSERTED;
                     rsp_in.slot   = slot_field(free_idx_ff);
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
               default: begin
                  if (!found_ff) begin
                     rsp_in.status = ST_UNKNOWN;
                  end else if (have_ff) begin
                     rsp_in.status   = ST_MATCH;
                     rsp_in.slot     = slot_field(hold_idx_ff);
                     rsp_in.hit_key  = hold_ent_ff.key;
                     rsp_in.hit_kind = hold_ent_ff.kind;
                     rsp_in.hit_x    = hold_ent_ff.x;
                     rsp_in.hit_y    = hold_ent_ff.y;
                     rsp_in.dist_sq  = hold_d2_ff;
                  end
               end
            endcase
         end
      end
   end

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= '{key: cur_ff.key, kind: cur_ff.kind, x: cur_ff.pos_x,
                             y: cur_ff.pos_y, alive: cur_ff.alive};
      end
      if (ctl.rd_en) begin
         q_ff     <= mem_ff[ctl.rd_addr];
         q_idx_ff <= ctl.rd_addr;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.flush) begin
         cur_ff <= req_data;
      end
      limit_ff     <= LIMIT_W'(cur_ff.reach) * LIMIT_W'(cur_ff.reach);
      found_idx_ff <= found_idx_in;
      seek_x_ff    <= seek_x_in;
      seek_y_ff    <= seek_y_in;
      free_idx_ff  <= free_idx_in;
      hold_idx_ff  <= hold_idx_in;
      hold_ent_ff  <= hold_ent_in;
      hold_d2_ff   <= hold_d2_in;
      rsp_ff       <= rsp_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff   <= 1'b0;
         valid_ff   <= '0;
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         have_ff    <= 1'b0;
         hits_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         q_vld_ff   <= q_vld_in;
         valid_ff   <= valid_in;
         found_ff   <= found_in;
         free_ff    <= free_in;
         have_ff    <= have_in;
         hits_ff    <= hits_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into an occupied output register");

   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !found_ff) |-> !valid_ff[wr_idx])
      else $error("insert overwrote a valid slot");

   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= HITS_W'(MAX_RESULTS))
      else $error("range hit count beyond the result limit");

   a_found_valid: assert property (@(posedge clock) disable iff (reset)
      found_ff |=> (!found_ff || valid_ff[found_idx_ff]))
      else $error("seeker slot is not valid");
`endif

endmodule

>>> verif/etns_checker.sv
// ----------------------------------------------------------------------------
// etns_checker
// Watches both channels of the entity table search block, keeps a shadow copy
// of the table, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module etns_checker (
   input  logic clock,
   input  logic reset,
   etns_req_if  req_mon,
   etns_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import etns_pkg::*;

   // Shadow copy of the entity table.
   logic              ent_valid [MAX_ENTITIES];
   logic [KEY_W-1:0]  ent_key   [MAX_ENTITIES];
   logic [BYTE_W-1:0] ent_kind  [MAX_ENTITIES];
   logic [BYTE_W-1:0] ent_x     [MAX_ENTITIES];
   logic [BYTE_W-1:0] ent_y     [MAX_ENTITIES];
   logic              ent_alive [MAX_ENTITIES];

   // Result beats owed by the block, oldest first.
   rsp_type search_results_due [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   // Adds one owed result beat at the tail of the queue.
   function automatic void owe_result(input rsp_type r);
      search_results_due = {search_results_due, r};
   endfunction

   function automatic int find_entity(input logic [KEY_W-1:0] k);
      for (int i = 0; i < MAX_ENTITIES; i++) begin
         if (ent_valid[i] && ent_key[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic int unsigned sq_distance(input int a, input int b);
      int dx;
      int dy;
      dx = int'(ent_x[a]) - int'(ent_x[b]);
      dy = int'(ent_y[a]) - int'(ent_y[b]);
      return dx * dx + dy * dy;
   endfunction

   function automatic rsp_type entity_hit(input int i, input int unsigned d2,
                                          input logic is_last);
      rsp_type h;
      h          = '0;
      h.status   = ST_MATCH;
      h.slot     = SLOT_FIELD_W'(i);
      h.hit_key  = ent_key[i];
      h.hit_kind = ent_kind[i];
      h.hit_x    = ent_x[i];
      h.hit_y    = ent_y[i];
      h.dist_sq  = DIST_W'(d2);
      h.last     = is_last;
      return h;
   endfunction

   // Applies one accepted command to the shadow table and queues its results.
   task automatic apply_table_command(input req_type r);
      rsp_type     res;
      int          idx;
      int          best;
      int          hits;
      int unsigned d2;
      int unsigned best_d2;
      int unsigned limit;
      res      = '0;
      res.last = 1'b1;
      best_d2  = 0;
      case (r.cmd)
         CMD_UPDATE: begin
            idx        = find_entity(r.key);
            res.status = ST_UPDATED;
            if (idx < 0) begin
               for (int i = 0; i < MAX_ENTITIES; i++) begin
                  if (!ent_valid[i]) begin
                     idx = i;
                     break;
                  end
               end
               if (idx < 0) begin
                  res.status = ST_FULL;
               end else begin
                  res.status     = ST_INSERTED;
                  ent_valid[idx] = 1'b1;
                  ent_key[idx]   = r.key;
               end
            end
            if (idx >= 0) begin
               ent_kind[idx]  = r.kind;
               ent_x[idx]     = r.pos_x;
               ent_y[idx]     = r.pos_y;
               ent_alive[idx] = r.alive;
               res.slot       = SLOT_FIELD_W'(idx);
            end
            owe_result(res);
         end
         CMD_NEAREST, CMD_RANGE: begin
            idx = find_entity(r.key);
            if (idx < 0) begin
               res.status = ST_UNKNOWN;
               owe_result(res);
            end else begin
               best  = -1;
               hits  = 0;
               limit = int'(r.reach) * int'(r.reach);
               // The seeker's own alive flag does not matter, only the others'.
               for (int i = 0; i < MAX_ENTITIES; i++) begin
                  if (!ent_valid[i] || i == idx || !ent_alive[i]) continue;
                  d2 = sq_distance(i, idx);
                  if (r.cmd == CMD_NEAREST) begin
                     if (best < 0 || d2 < best_d2) begin
                        best    = i;
                        best_d2 = d2;
                     end
                  end else if (d2 <= limit && hits < MAX_RESULTS) begin
                     owe_result(entity_hit(i, d2, 1'b0));
                     hits++;
                  end
               end
               if (r.cmd == CMD_NEAREST && best >= 0) begin
                  owe_result(entity_hit(best, best_d2, 1'b1));
               end else if (r.cmd == CMD_RANGE && hits > 0) begin
                  search_results_due[search_results_due.size() - 1].last = 1'b1;
               end else begin
                  res.status = ST_NO_MATCH;
                  owe_result(res);
               end
            end
         end
         default: begin
            // The unused command is swallowed without a result.
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("Result field %s mismatch: expected 0x%0h, actual 0x%0h",
                name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      req_type seen;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_ENTITIES; i++) ent_valid[i] = 1'b0;
         search_results_due.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            seen.cmd   = cmd_type'(req_mon.cmd);
            seen.key   = req_mon.key;
            seen.kind  = req_mon.kind;
            seen.pos_x = req_mon.pos_x;
            seen.pos_y = req_mon.pos_y;
            seen.alive = req_mon.alive;
            seen.reach = req_mon.reach;
            apply_table_command(seen);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (search_results_due.size() == 0) begin
               $error("Result beat arrived with no result outstanding");
               fail_count++;
            end else begin
               want = search_results_due.pop_front();
               check_field("status",   want.status,   rsp_mon.status);
               check_field("slot",     want.slot,     rsp_mon.slot);
               check_field("hit_key",  want.hit_key,  rsp_mon.hit_key);
               check_field("hit_kind", want.hit_kind, rsp_mon.hit_kind);
               check_field("hit_x",    want.hit_x,    rsp_mon.hit_x);
               check_field("hit_y",    want.hit_y,    rsp_mon.hit_y);
               check_field("dist_sq",  want.dist_sq,  rsp_mon.dist_sq);
               check_field("last",     want.last,     rsp_mon.last);
               checked++;
            end
         end
      end
      pending = search_results_due.size();
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the entity table search block. A directed opening
// walks the table through its corner cases and fills it; a random phase then
// mixes updates and queries on the known keys with unknown keys and the
// unused command, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import etns_pkg::*;

   // Number of random request beats after the directed opening.
   localparam int RANDOM_ITEMS    = 90;
   // Random beat after which the long response hold-off is armed.
   localparam int HOLD_ARM_ITEM   = 40;
   // Length of the one long response hold-off, in cycles.
   localparam int HOLD_OFF_CYCLES = 300;
   // Quiet time after the last expected beat: a full query plus margin.
   localparam int DRAIN_CYCLES    = 2 * MAX_ENTITIES + 8;
   // Hard stop.
   localparam int CYCLE_LIMIT     = 200000;

   logic clock;
   logic reset;

   etns_req_if req_bus ();
   etns_rsp_if rsp_bus ();

   int fail_count;
   int pending;
   int checked;

   // Beats sent, and how many of them belonged to the directed opening.
   int sent;
   int directed_sent;

   // Sender burst state: beats left in the current burst.
   int burst_left;

   // Handshake between the stimulus and the receiver for the long hold-off.
   bit hold_armed;
   bit hold_done;

   // Keys that the stimulus has put into the table.
   logic [KEY_W-1:0] key_pool [$];

   entity_table_nearest_search_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   etns_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // 4 ns clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Reset is asserted at the start and never raised again.
   initial begin
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: if the run is still going at the limit, something has hung.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $error("Run did not finish within %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending);
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver. It alternates segments of random length in which it is always
   // ready, ready half of the time or ready a quarter of the time. Once the
   // stimulus arms it, it holds ready low for a long stretch so that a result
   // backs up inside the block and the request side stalls behind it.
   initial begin
      int seg_len;
      int mode;
      rsp_bus.ready <= 1'b0;
      hold_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_armed && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            seg_len = $urandom_range(16, 64);
            mode    = $urandom_range(0, 2);
            repeat (seg_len) begin
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;
                  1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                  default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Adds a key to the pool that the random phase draws from.
   function automatic void remember_key(input logic [KEY_W-1:0] k);
      key_pool = {key_pool, k};
   endfunction

   function automatic req_type make_req(input cmd_type c, input logic [KEY_W-1:0] k,
                                        input logic [BYTE_W-1:0] kd,
                                        input logic [BYTE_W-1:0] x,
                                        input logic [BYTE_W-1:0] y,
                                        input logic al, input logic [REACH_W-1:0] rc);
      req_type r;
      r.cmd   = c;
      r.key   = k;
      r.kind  = kd;
      r.pos_x = x;
      r.pos_y = y;
      r.alive = al;
      r.reach = rc;
      return r;
   endfunction

   // Offers one beat and returns at the edge where it is accepted. Valid stays
   // high into the next beat unless the burst has just ended, in which case
   // the sender goes quiet for a random gap. A gap of zero gives back-to-back
   // bursts, so long stretches without idling happen as well.
   task automatic drive_item(input req_type it);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= it.cmd;
      req_bus.key   <= it.key;
      req_bus.kind  <= it.kind;
      req_bus.pos_x <= it.pos_x;
      req_bus.pos_y <= it.pos_y;
      req_bus.alive <= it.alive;
      req_bus.reach <= it.reach;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // One random beat. Most beats are updates and queries on keys already in
   // the table, so that the searches have real neighbors to find. Positions
   // are often packed into a small patch to give ties and range hits. The rest
   // are keys the table has never seen (dropped inserts, unknown seekers) and
   // the unused command. Fields a command ignores are still randomized.
   function automatic req_type random_item();
      req_type          r;
      int               sel;
      logic [KEY_W-1:0] pool_key;
      pool_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      sel      = $urandom_range(0, 99);
      r.key    = pool_key;
      r.kind   = BYTE_W'($urandom);
      if ($urandom_range(0, 1) == 0) begin
         r.pos_x = BYTE_W'($urandom_range(120, 136));
         r.pos_y = BYTE_W'($urandom_range(120, 136));
      end else begin
         r.pos_x = BYTE_W'($urandom);
         r.pos_y = BYTE_W'($urandom);
      end
      r.alive = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
         0, 1:    r.reach = REACH_W'($urandom_range(0, 40));
         2, 3:    r.reach = REACH_W'($urandom_range(0, 511));
         default: r.reach = ($urandom_range(0, 1) == 0) ? '0 : '1;
      endcase
      if (sel < 35) begin
         r.cmd = CMD_UPDATE;
      end else if (sel < 60) begin
         r.cmd = CMD_NEAREST;
      end else if (sel < 85) begin
         r.cmd = CMD_RANGE;
      end else if (sel < 90) begin
         r.cmd = CMD_UPDATE;
         r.key = $urandom;
      end else if (sel < 95) begin
         r.cmd = ($urandom_range(0, 1) == 0) ? CMD_NEAREST : CMD_RANGE;
         r.key = $urandom;
      end else begin
         r.cmd = CMD_NONE;
         r.key = $urandom;
      end
      return r;
   endfunction

   // Main stimulus and verdict.
   initial begin
      logic [KEY_W-1:0] fresh_key;
      sent          = 0;
      directed_sent = 0;
      burst_left    = $urandom_range(1, 12);
      hold_armed    = 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= CMD_NONE;
      req_bus.key   <= '0;
      req_bus.kind  <= '0;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      req_bus.alive <= 1'b0;
      req_bus.reach <= '0;
      wait (reset === 1'b0);
      @(posedge clock);

      // Queries on an empty table: the seeker is unknown.
      drive_item(make_req(CMD_NEAREST, 32'd1, 8'h00, 8'h00, 8'h00, 1'b0, 9'd0));
      drive_item(make_req(CMD_RANGE, 32'd1, 8'hff, 8'hff, 8'hff, 1'b1, 9'h1ff));
      // The unused command gives nothing back.
      drive_item(make_req(CMD_NONE, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 1'b1, 9'h1ff));

      // Two entities at opposite corners, with the extreme key and kind values.
      drive_item(make_req(CMD_UPDATE, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1, 9'd0));
      // Only the seeker itself is in the table: no match.
      drive_item(make_req(CMD_NEAREST, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1, 9'd0));
      drive_item(make_req(CMD_UPDATE, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 1'b1, 9'd0));
      remember_key(32'h0);
      remember_key(32'hffff_ffff);
      // Largest possible squared distance.
      drive_item(make_req(CMD_NEAREST, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0, 9'd0));
      // Range limits just below and just above the corner-to-corner distance,
      // then the widest reach from the other end.
      drive_item(make_req(CMD_RANGE, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0, 9'd360));
      drive_item(make_req(CMD_RANGE, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0, 9'd361));
      drive_item(make_req(CMD_RANGE, 32'hffff_ffff, 8'h00, 8'h00, 8'h00, 1'b0, 9'h1ff));

      // A dead entity on top of key 0. As a seeker its own flag is ignored,
      // so it finds key 0 at distance zero.
      drive_item(make_req(CMD_UPDATE, 32'd5, 8'h5a, 8'h00, 8'h00, 1'b0, 9'd0));
      remember_key(32'd5);
      drive_item(make_req(CMD_NEAREST, 32'd5, 8'h00, 8'h00, 8'h00, 1'b0, 9'd0));
      // Kill the far corner in place: every other entity is now dead.
      drive_item(make_req(CMD_UPDATE, 32'hffff_ffff, 8'ha5, 8'hff, 8'hff, 1'b0, 9'd0));
      drive_item(make_req(CMD_NEAREST, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0, 9'd0));

      // Fill the remaining slots with live entities stacked on one point.
      repeat (MAX_ENTITIES - 3) begin
         fresh_key = $urandom;
         remember_key(fresh_key);
         drive_item(make_req(CMD_UPDATE, fresh_key, BYTE_W'($urandom), 8'd128, 8'd128,
                             1'b1, 9'd0));
      end
      // The table is full, so a new key is dropped.
      drive_item(make_req(CMD_UPDATE, 32'h1234_5678, 8'h11, 8'h22, 8'h33, 1'b1, 9'd0));
      // Equal distances everywhere: the lowest slot wins the nearest search.
      drive_item(make_req(CMD_NEAREST, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0, 9'd0));
      // A range of zero from inside the stack hits all of its other members,
      // and the widest range from a corner returns a long list of hits.
      drive_item(make_req(CMD_RANGE, key_pool[3], 8'h00, 8'h00, 8'h00, 1'b0, 9'd0));
      drive_item(make_req(CMD_RANGE, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0, 9'h1ff));
      directed_sent = sent;

      // Random phase. Partway through, the receiver is told to hold off for a
      // long stretch while this process keeps offering beats.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_ARM_ITEM) hold_armed = 1'b1;
         drive_item(random_item());
      end
      req_bus.valid <= 1'b0;

      // Let the checker see the final acceptance, wait for every owed result,
      // then stay a little longer to catch any stray beat.
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Coverage: %0d request beats (%0d directed, %0d random), %0d results checked.",
               sent, directed_sent, sent - directed_sent, checked);
      $display("Included a full table, dead seekers, ties, and a %0d-cycle response stall.",
               HOLD_OFF_CYCLES);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
